>>> rtl/adt_pkg.sv
`default_nettype none
package adt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] ACT_FIRE  = 2'd0;
    localparam logic [1:0] ACT_LIST  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] SEV_INFO     = 2'd0;
    localparam logic [1:0] SEV_CRITICAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COOL_CRIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_WARN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_INFO = 2'd2;

    localparam logic [31:0] COOL_CRIT_RST = 32'd60000;
    localparam logic [31:0] COOL_WARN_RST = 32'd300000;
    localparam logic [31:0] COOL_INFO_RST = 32'd900000;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRE_RD,
        ST_FIRE_CHK,
        ST_MIN_RD,
        ST_MIN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_REFRESH,
        ST_LIST_RD,
        ST_LIST_CHK,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  severity;
        logic [15:0] component;
        logic [15:0] condition;
        logic [63:0] first_time;
        logic [63:0] last_time;
        logic [31:0] count;
    } entry_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  severity;
        logic [15:0] component_key;
        logic [15:0] condition_key;
        logic [63:0] now_ms;
        logic [4:0]  list_limit;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  entry_index;
        logic [1:0]  out_severity;
        logic [15:0] out_component;
        logic [15:0] out_condition;
        logic [63:0] out_first_time;
        logic [63:0] out_last_time;
        logic [31:0] out_occurrences;
        logic        last_of_run;
    } out_item_t;

    // Selects the cooldown window for a severity code.
    function automatic logic [31:0] window_of(input logic [1:0] sev,
                                              input logic [31:0] crit,
                                              input logic [31:0] warn,
                                              input logic [31:0] info);
        logic [31:0] w;
        unique case (sev)
            SEV_INFO:     w = info;
            SEV_CRITICAL: w = crit;
            default:      w = warn;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/adt_if.sv
`default_nettype none
interface adt_in_if;
    logic                    valid;
    logic                    ready;
    adt_pkg::in_item_t       data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adt_out_if;
    logic                    valid;
    logic                    ready;
    adt_pkg::out_item_t      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/adt_entry_ram.sv
`default_nettype none
module adt_entry_ram (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [adt_pkg::IDX_W-1:0] waddr,
    input  wire adt_pkg::entry_t          wdata,
    input  wire logic [adt_pkg::IDX_W-1:0] raddr,
    output adt_pkg::entry_t               rdata
);
    import adt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> rtl/alert_dedup_table.sv
// Fire: one read and one compare per entry over the table until an entry matches in its window,
// plus an oldest search and a shift when the table is full and nothing matches, then the append.
// List: scans the entries and marks live ones up to the capped limit, then hands each one out.
// Clear empties the table. The rate is set by the one read per cycle of the entry memory.
// Reset clears the entry count and the control state; the cooldown
// registers return to their documented defaults. The memory is not cleared.
`default_nettype none
module alert_dedup_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    adt_in_if.sink                             in_ch,
    adt_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [adt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [adt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import adt_pkg::*;

    state_t          state_reg, state_next;
    in_item_t        item_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] sel_reg, sel_next;
    logic [63:0]     min_reg, min_next;
    logic [CNT_W-1:0] nlist_reg, nlist_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic [TABLE_DEPTH-1:0] hit_reg, hit_next;
    logic [31:0]     cool_crit_reg, cool_warn_reg, cool_info_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;

    logic            ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t          ram_wdata, ram_rdata;

    logic [4:0]      limit_cap;
    logic [63:0]     age;
    logic [31:0]     win_in, win_st;
    logic            key_eq;
    logic            emit_fire, emit_list;
    logic [IDX_W-1:0] next_hit;

    adt_entry_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared age and compare unit.
    assign age    = item_reg.now_ms - ram_rdata.last_time;
    assign win_in = window_of(item_reg.severity, cool_crit_reg, cool_warn_reg, cool_info_reg);
    assign win_st = window_of(ram_rdata.severity, cool_crit_reg, cool_warn_reg, cool_info_reg);
    assign key_eq = (ram_rdata.component == item_reg.component_key)
                 && (ram_rdata.condition == item_reg.condition_key);
    assign limit_cap = (item_reg.list_limit > 5'd16) ? 5'd16 : item_reg.list_limit;

    // Lowest marked list entry.
    always_comb
    begin
        next_hit  = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
            begin
                next_hit  = IDX_W'(k);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_crit_reg <= COOL_CRIT_RST;
            cool_warn_reg <= COOL_WARN_RST;
            cool_info_reg <= COOL_INFO_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COOL_CRIT) cool_crit_reg <= cfg_data;
            if (cfg_index == REG_COOL_WARN) cool_warn_reg <= cfg_data;
            if (cfg_index == REG_COOL_INFO) cool_info_reg <= cfg_data;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    priority if (in_ch.data.action == ACT_FIRE)
                        state_next = (used_reg == '0) ? ST_APPEND : ST_FIRE_RD;
                    else if (in_ch.data.action == ACT_LIST)
                        state_next = (used_reg == '0) ? ST_IDLE : ST_LIST_RD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FIRE_RD:  state_next = ST_FIRE_CHK;
            ST_FIRE_CHK:
            begin
                priority if (key_eq && (age < {32'd0, win_in}))
                    state_next = ST_REFRESH;
                else if (ptr_reg + 1'b1 < used_reg)
                    state_next = ST_FIRE_RD;
                else if (used_reg == CNT_W'(TABLE_DEPTH))
                    state_next = ST_MIN_RD;
                else
                    state_next = ST_APPEND;
            end
            ST_REFRESH:  state_next = ST_OUT_RD;
            ST_MIN_RD:   state_next = ST_MIN_CHK;
            ST_MIN_CHK:
                state_next = (ptr_reg == CNT_W'(TABLE_DEPTH - 1)) ? ST_SHIFT_RD : ST_MIN_RD;
            ST_SHIFT_RD:
                state_next = (ptr_reg >= CNT_W'(TABLE_DEPTH - 1)) ? ST_APPEND : ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_APPEND:   state_next = ST_OUT_RD;
            ST_LIST_RD:  state_next = ST_LIST_CHK;
            ST_LIST_CHK:
            begin
                if ((ptr_reg + 1'b1 < used_reg) && (nlist_next < limit_cap))
                    state_next = ST_LIST_RD;
                else if (nlist_next == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_OUT_RD;
            end
            ST_OUT_RD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (item_reg.action == ACT_LIST && ocnt_reg + 1'b1 < nlist_reg)
                        state_next = ST_OUT_RD;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and memory access.
    always_comb
    begin
        used_next  = used_reg;
        ptr_next   = ptr_reg;
        sel_next   = sel_reg;
        min_next   = min_reg;
        nlist_next = nlist_reg;
        ocnt_next  = ocnt_reg;
        hit_next   = hit_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg[IDX_W-1:0];
        ram_wdata  = ram_rdata;
        ram_raddr  = ptr_reg[IDX_W-1:0];
        emit_fire  = 1'b0;
        emit_list  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ptr_next   = '0;
                nlist_next = '0;
                ocnt_next  = '0;
                hit_next   = '0;
                min_next   = '1;
                sel_next   = '0;
                if (in_ch.valid && in_ch.ready && in_ch.data.action == ACT_CLEAR)
                    used_next = '0;
            end
            ST_FIRE_RD: ;
            ST_FIRE_CHK:
            begin
                if (key_eq && (age < {32'd0, win_in}))
                    sel_next = ptr_reg[IDX_W-1:0];
                else if (ptr_reg + 1'b1 < used_reg)
                    ptr_next = ptr_reg + 1'b1;
                else
                    ptr_next = '0;
            end
            ST_REFRESH:
            begin
                ram_we    = 1'b1;
                ram_waddr = sel_reg;
                ram_wdata.last_time = item_reg.now_ms;
                if (ram_rdata.count != COUNT_MAX)
                    ram_wdata.count = ram_rdata.count + 32'd1;
            end
            ST_MIN_RD: ;
            ST_MIN_CHK:
            begin
                if (ptr_reg == '0 || ram_rdata.last_time < min_reg)
                begin
                    min_next = ram_rdata.last_time;
                    sel_next = ptr_reg[IDX_W-1:0];
                end
                if (ptr_reg == CNT_W'(TABLE_DEPTH - 1))
                    ptr_next = {1'b0, (ptr_reg == '0 || ram_rdata.last_time < min_reg)
                                      ? ptr_reg[IDX_W-1:0] : sel_reg};
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            ST_SHIFT_RD:
            begin
                ram_raddr = IDX_W'(ptr_reg + 1'b1);
                if (ptr_reg >= CNT_W'(TABLE_DEPTH - 1))
                    used_next = used_reg - 1'b1;
            end
            ST_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IDX_W-1:0];
                ptr_next  = ptr_reg + 1'b1;
            end
            ST_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = used_reg[IDX_W-1:0];
                ram_wdata.severity   = item_reg.severity;
                ram_wdata.component  = item_reg.component_key;
                ram_wdata.condition  = item_reg.condition_key;
                ram_wdata.first_time = item_reg.now_ms;
                ram_wdata.last_time  = item_reg.now_ms;
                ram_wdata.count      = 32'd1;
                sel_next  = used_reg[IDX_W-1:0];
                used_next = used_reg + 1'b1;
            end
            ST_LIST_RD: ;
            ST_LIST_CHK:
            begin
                // Only entries up to the capped limit are marked.
                if ((age < {32'd0, win_st}) && (nlist_reg < limit_cap))
                begin
                    hit_next[ptr_reg[IDX_W-1:0]] = 1'b1;
                    nlist_next = nlist_reg + 1'b1;
                end
                ptr_next = ptr_reg + 1'b1;
            end
            ST_OUT_RD:
            begin
                if (item_reg.action == ACT_LIST)
                    sel_next = next_hit;
                ram_raddr = (item_reg.action == ACT_LIST) ? next_hit : sel_reg;
            end
            ST_OUT:
            begin
                // Keep reading the selected entry while the output is stalled.
                ram_raddr = sel_reg;
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (item_reg.action == ACT_LIST)
                    begin
                        emit_list = 1'b1;
                        hit_next[sel_reg] = 1'b0;
                        ocnt_next = ocnt_reg + 1'b1;
                    end
                    else
                        emit_fire = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (emit_fire || emit_list)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        sel_reg   <= sel_next;
        min_reg   <= min_next;
        nlist_reg <= nlist_next;
        ocnt_reg  <= ocnt_next;
        hit_reg   <= hit_next;
        if (in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
    end

    // Output register: one transfer waits here while the sequencer moves on.
    always_ff @(posedge clk)
    begin
        if (emit_fire || emit_list)
        begin
            out_reg.result_kind     <= emit_list;
            out_reg.entry_index     <= sel_reg;
            out_reg.out_severity    <= ram_rdata.severity;
            out_reg.out_component   <= ram_rdata.component;
            out_reg.out_condition   <= ram_rdata.condition;
            out_reg.out_first_time  <= ram_rdata.first_time;
            out_reg.out_last_time   <= ram_rdata.last_time;
            out_reg.out_occurrences <= ram_rdata.count;
            out_reg.last_of_run     <= emit_fire || (ocnt_reg + 1'b1 == nlist_reg);
        end
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // The entry count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A fire answer always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.data.result_kind) |-> out_ch.data.last_of_run)
        else $error("fire answer without end mark");

    // An append always leaves the table non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPEND) |=> (used_reg != '0))
        else $error("append left table empty");

    // A held result is never overwritten before its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
        else $error("pending result changed");
endmodule
`default_nettype wire
